// File: sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial-division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // First trial divisor
    localparam int unsigned FIRST_DIVISOR = 2;

    // Width of the result stream payload (is_prime padded to one byte)
    localparam int unsigned OUT_TDATA_W = 8;

endpackage

// File: sv/tdpt_div.sv
// ----------------------------------------------------------------------------
// tdpt_div
// Iterative restoring divider: one quotient bit per cycle, NUM_BITS bits in all.
// ----------------------------------------------------------------------------
module tdpt_div
    import tdpt_pkg::*;
#(
    parameter int unsigned NUM_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [NUM_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot,
    output logic [NUM_BITS-1:0] o_rem
);

    localparam int unsigned CNT_W = $clog2(NUM_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_BITS-1:0] r_num;
    logic [NUM_BITS-1:0] r_den;
    logic [NUM_BITS-1:0] r_quot;
    logic [NUM_BITS-1:0] r_rem;

    logic [NUM_BITS:0]   w_shift;
    logic [NUM_BITS+1:0] w_diff;
    logic                w_ge;
    logic [NUM_BITS-1:0] n_rem;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        w_shift = {r_rem, r_num[NUM_BITS-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_den};
        w_ge    = ~w_diff[NUM_BITS+1];
        n_rem   = w_ge ? w_diff[NUM_BITS-1:0] : w_shift[NUM_BITS-1:0];
    end

    // Control: busy flag, step counter, completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_BITS-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[NUM_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    // A new division is never launched over one in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && r_busy))
        else $error("divider restarted while busy");

    // Completion pulse only once the iteration has stopped
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    // Remainder is reduced below the divisor at completion
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule

// File: sv/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division on a shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   A request arrives on the s_axis channel: the candidate sits in the low
//   NUM_BITS bits of s_axis_tdata. s_axis_tready is high only while the
//   block is idle, so one candidate is worked on at a time.
//   The verdict leaves on m_axis: bit 0 of m_axis_tdata is 1 for a prime.
//   Each trial divisor d = 2, 3, ... costs one pass of the divider and a
//   visit to the check state. The quotient n / d both bounds the search
//   (stop once d > n / d) and the remainder flags a factor. A composite
//   finishes sooner than a prime, as the search stops at its first
//   factor; zero and one skip the divider and go straight to the verdict.
//   The result sits in an output register; a stalled receiver holds it, and
//   the block may take and work on the next candidate meanwhile, waiting
//   only to hand over its own verdict.
//   Reset (synchronous, active low) drops any candidate in progress and
//   empties the output register.
// ----------------------------------------------------------------------------
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int unsigned NUM_BITS = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [NUM_BITS-1:0] candidate, upper bits zero padding
    input  logic [((NUM_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] is_prime, [7:1] zero padding
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata
);

    t_state              r_state;
    t_state              n_state;
    logic [NUM_BITS-1:0] r_n;
    logic [NUM_BITS-1:0] r_d;
    logic                r_result;
    logic                r_out_valid;
    logic                r_out_bit;

    logic                w_in_acc;
    logic                w_small;
    logic                w_out_free;
    logic                w_bound_hit;
    logic                w_factor;
    logic [NUM_BITS-1:0] w_cand;
    logic [NUM_BITS-1:0] w_d_next;

    logic                w_div_start;
    logic [NUM_BITS-1:0] w_div_dividend;
    logic [NUM_BITS-1:0] w_div_divisor;
    logic                w_div_done;
    logic [NUM_BITS-1:0] w_div_quot;
    logic [NUM_BITS-1:0] w_div_rem;

    // Request decode and per-divisor verdict
    assign w_cand      = s_axis_tdata[NUM_BITS-1:0];
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_small     = (w_cand < NUM_BITS'(FIRST_DIVISOR));
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_bound_hit = (r_d > w_div_quot);
    assign w_factor    = (w_div_rem == '0);
    assign w_d_next    = r_d + 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = w_small ? ST_FINISH : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (w_div_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (w_bound_hit || w_factor) ? ST_FINISH : ST_DIVIDE;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider launch
    always_comb begin
        s_axis_tready  = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = r_n;
        w_div_divisor  = w_d_next;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready  = 1'b1;
                w_div_start    = s_axis_tvalid && !w_small;
                w_div_dividend = w_cand;
                w_div_divisor  = NUM_BITS'(FIRST_DIVISOR);
            end
            ST_CHECK: begin
                w_div_start = !(w_bound_hit || w_factor);
            end
            ST_DIVIDE, ST_FINISH: begin
                w_div_start = 1'b0;
            end
            default: w_div_start = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Candidate, divisor and pending verdict
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc) begin
            r_n      <= w_cand;
            r_d      <= NUM_BITS'(FIRST_DIVISOR);
            r_result <= 1'b0;
        end else if (r_state == ST_CHECK) begin
            r_d      <= w_d_next;
            r_result <= w_bound_hit;
        end
    end

    // Output register: hold the verdict until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && w_out_free) begin
            r_out_bit <= r_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W-1)'(0), r_out_bit};

    // Shared divider
    tdpt_div #(
        .NUM_BITS (NUM_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // A check always follows a completed division
    a_check_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> $past(w_div_done))
        else $error("check without a finished division");

    // Zero and one go straight to a composite verdict
    a_small_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_small) |=> (r_state == ST_FINISH && !r_result))
        else $error("zero or one not rejected at once");

    // A prime verdict is only ever reached for a candidate of at least two
    a_prime_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_result) |-> (r_n >= NUM_BITS'(FIRST_DIVISOR)))
        else $error("prime verdict on candidate below two");

endmodule
